[design/fsp_pkg.sv]
// Shared types and constants of the saturating FIR filter.
package fsp_pkg;

   // Field widths fixed by the item format
   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 16;
   localparam int INDEX_W    = 6;
   localparam int TAPCNT_W   = 7;
   localparam int PROD_W     = SAMPLE_W + COEF_W;
   localparam int OUT_LIMIT  = 32767;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] REG_TAP_COUNT = 1'b0;
   localparam logic [TAPCNT_W-1:0] TAPCNT_RESET = 7'd64;

   // Depth of the command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic {
      OP_FILTER = 1'b0,
      OP_LOAD   = 1'b1
   } op_type;

   // One classified item on its way to the back end
   typedef struct packed {
      op_type                     op;
      logic                       start;
      logic signed [SAMPLE_W-1:0] sample;
      logic [INDEX_W-1:0]         index;
      logic signed [COEF_W-1:0]   coef;
   } cmd_type;

endpackage

[design/fsp_req_if.sv]
// Input and result channel interfaces of the FIR filter.
interface fsp_req_if;
   logic                               valid;
   logic                               ready;
   logic                               operation;
   logic                               start_of_block;
   logic signed [fsp_pkg::SAMPLE_W-1:0] sample_value;
   logic [fsp_pkg::INDEX_W-1:0]        coefficient_index;
   logic signed [fsp_pkg::COEF_W-1:0]   coefficient_value;

   modport source (output valid, operation, start_of_block, sample_value,
                   coefficient_index, coefficient_value, input ready);
   modport sink   (input valid, operation, start_of_block, sample_value,
                   coefficient_index, coefficient_value, output ready);
endinterface

interface fsp_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [fsp_pkg::SAMPLE_W-1:0] filtered_sample;

   modport source (output valid, filtered_sample, input ready);
   modport sink   (input valid, filtered_sample, output ready);
endinterface

[design/fsp_queue.sv]
// Short command queue between the front end and the filter back end.
module fsp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  fsp_pkg::cmd_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output fsp_pkg::cmd_type pop_data
);

   localparam int DEPTH = fsp_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   fsp_pkg::cmd_type   entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               push, pop;

   assign push_ready = (cnt_ff != CNT_W'(DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[design/fsp_front.sv]
// Front end: takes input items, classifies them and holds the tap count register.
module fsp_front #(
   parameter int MAX_TAPS = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   fsp_req_if.sink                           req_bus,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [fsp_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [fsp_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [fsp_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready,
   output logic                              push_valid,
   input  logic                              push_ready,
   output fsp_pkg::cmd_type                  push_data,
   output logic [fsp_pkg::TAPCNT_W-1:0]      tap_count
);

   localparam int IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int CI_W  = ((fsp_pkg::INDEX_W > IDX_W) ? fsp_pkg::INDEX_W : IDX_W) + 1;

   logic [fsp_pkg::TAPCNT_W-1:0] tap_count_ff, tap_count_in;
   logic [0:0]                   reg_sel;
   logic                         csr_write;
   logic                         in_range;
   fsp_pkg::op_type              op;

   // Register decode, one word per register
   assign reg_sel   = paddr[2];
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign prdata    = (reg_sel == fsp_pkg::REG_TAP_COUNT) ?
                      fsp_pkg::CSR_DATA_W'(tap_count_ff) : '0;
   assign tap_count = tap_count_ff;

   always_comb begin
      tap_count_in = tap_count_ff;
      if (csr_write && (reg_sel == fsp_pkg::REG_TAP_COUNT)) begin
         tap_count_in = pwdata[fsp_pkg::TAPCNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= fsp_pkg::TAPCNT_RESET;
      end else begin
         tap_count_ff <= tap_count_in;
      end
   end

   // Classification: loads beyond the tap store are taken and dropped here
   assign op       = fsp_pkg::op_type'(req_bus.operation);
   assign in_range = (CI_W'(req_bus.coefficient_index) < CI_W'(MAX_TAPS));

   assign req_bus.ready = push_ready;
   assign push_valid    = req_bus.valid && ((op == fsp_pkg::OP_FILTER) || in_range);

   assign push_data.op     = op;
   assign push_data.start  = req_bus.start_of_block;
   assign push_data.sample = req_bus.sample_value;
   assign push_data.index  = req_bus.coefficient_index;
   assign push_data.coef   = req_bus.coefficient_value;

endmodule

[design/fsp_back.sv]
// Back end: tap store, delay line, shared multiply-accumulate and output rounding.
module fsp_back #(
   parameter int MAX_TAPS       = 64,
   parameter int COEF_FRAC_BITS = 15
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   output logic                          cmd_ready,
   input  fsp_pkg::cmd_type              cmd_data,
   input  logic [fsp_pkg::TAPCNT_W-1:0]  tap_count,
   fsp_rsp_if.source                     rsp_bus
);

   localparam int IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int ACC_W = fsp_pkg::PROD_W + IDX_W + 1;
   localparam int CMP_W = ((IDX_W > fsp_pkg::TAPCNT_W) ? IDX_W : fsp_pkg::TAPCNT_W) + 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TAPS - 1);
   localparam logic signed [ACC_W-1:0] RND_BIAS =
      ACC_W'((longint'(1) << COEF_FRAC_BITS) - 1);
   localparam logic signed [ACC_W-1:0] POS_LIM = ACC_W'(fsp_pkg::OUT_LIMIT);
   localparam logic signed [ACC_W-1:0] NEG_LIM = -POS_LIM;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_MAC   = 5'b00010,
      ST_DRAIN = 5'b00100,
      ST_ROUND = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   state_type                            state_ff, state_in;
   logic [IDX_W-1:0]                     cnt_ff, cnt_in;
   logic signed [fsp_pkg::SAMPLE_W-1:0]  hist_ff [MAX_TAPS];
   logic signed [fsp_pkg::SAMPLE_W-1:0]  hist_in [MAX_TAPS];
   logic signed [fsp_pkg::COEF_W-1:0]    tap_mem [MAX_TAPS];
   logic [MAX_TAPS-1:0]                  tap_vld_ff;
   logic signed [fsp_pkg::COEF_W-1:0]    rd_coef_ff;
   logic                                 rd_vld_ff;
   logic signed [fsp_pkg::SAMPLE_W-1:0]  s1_samp_ff;
   logic                                 s1_act_ff, s1_en_ff;
   logic signed [fsp_pkg::PROD_W-1:0]    s2_prod_ff, s2_prod_in;
   logic                                 s2_act_ff;
   logic signed [ACC_W-1:0]              acc_ff, acc_in;
   logic signed [ACC_W-1:0]              quo_ff, biased;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic signed [fsp_pkg::SAMPLE_W-1:0]  rsp_data_ff, sat_val;
   logic                                 pop, load_wr, sample_pop, out_fire;
   logic [IDX_W-1:0]                     wr_addr;

   assign cmd_ready  = (state_ff == ST_IDLE);
   assign pop        = cmd_valid && cmd_ready;
   assign load_wr    = pop && (cmd_data.op == fsp_pkg::OP_LOAD);
   assign sample_pop = pop && (cmd_data.op == fsp_pkg::OP_FILTER);
   assign wr_addr    = IDX_W'(cmd_data.index);
   assign out_fire   = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_bus.ready);

   // Sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (sample_pop) begin
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_IDX) begin
               cnt_in   = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!s1_act_ff && !s2_act_ff) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Delay line: shift in on a sample, clearing older ones at a block start; rotate one place per MAC step
   always_comb begin
      hist_in = hist_ff;
      if (sample_pop) begin
         for (int j = 1; j < MAX_TAPS; j++) begin
            hist_in[j] = cmd_data.start ? '0 : hist_ff[j-1];
         end
         hist_in[0] = cmd_data.sample;
      end else if (state_ff == ST_MAC) begin
         for (int j = 0; j < MAX_TAPS - 1; j++) begin
            hist_in[j] = hist_ff[j+1];
         end
         hist_in[MAX_TAPS-1] = hist_ff[0];
      end
   end

   // Multiply and accumulate; taps never written read as zero
   always_comb begin
      s2_prod_in = '0;
      if (s1_en_ff && rd_vld_ff) begin
         s2_prod_in = rd_coef_ff * s1_samp_ff;
      end
      acc_in = acc_ff;
      if (sample_pop) begin
         acc_in = '0;
      end else if (s2_act_ff) begin
         acc_in = acc_ff + ACC_W'(s2_prod_ff);
      end
   end

   // Truncate toward zero, then saturate symmetrically
   assign biased = acc_ff + (acc_ff[ACC_W-1] ? RND_BIAS : '0);

   always_comb begin
      if (quo_ff > POS_LIM) begin
         sat_val = fsp_pkg::SAMPLE_W'(fsp_pkg::OUT_LIMIT);
      end else if (quo_ff < NEG_LIM) begin
         sat_val = -fsp_pkg::SAMPLE_W'(fsp_pkg::OUT_LIMIT);
      end else begin
         sat_val = quo_ff[fsp_pkg::SAMPLE_W-1:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers and delay line
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         s1_act_ff    <= 1'b0;
         s2_act_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tap_vld_ff   <= '0;
         for (int j = 0; j < MAX_TAPS; j++) begin
            hist_ff[j] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         s1_act_ff    <= (state_ff == ST_MAC);
         s2_act_ff    <= s1_act_ff;
         rsp_valid_ff <= rsp_valid_in;
         hist_ff      <= hist_in;
         if (load_wr) begin
            tap_vld_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      rd_vld_ff  <= tap_vld_ff[cnt_ff];
      s1_samp_ff <= hist_ff[0];
      s1_en_ff   <= (CMP_W'(cnt_ff) < CMP_W'(tap_count));
      s2_prod_ff <= s2_prod_in;
      acc_ff     <= acc_in;
      if (state_ff == ST_ROUND) begin
         quo_ff <= biased >>> COEF_FRAC_BITS;
      end
      if (out_fire) begin
         rsp_data_ff <= sat_val;
      end
   end

   // Tap weight store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (load_wr) begin
         tap_mem[wr_addr] <= cmd_data.coef;
      end
      rd_coef_ff <= tap_mem[cnt_ff];
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.filtered_sample = rsp_data_ff;

endmodule

[design/fir_filter_saturating_core.sv]
// Top level of the saturating direct-form FIR filter.
// Items enter on req_bus: a coefficient load writes one Q1.15 weight and
// gives no result; a sample item gives one filtered sample on rsp_bus, the
// sum over the first tap_count taps shifted down by COEF_FRAC_BITS toward
// zero and clamped to +/-32767. The front end accepts and sorts items into
// a two-entry queue, so up to two items are taken while the back end works.
// The back end runs one multiplier over every tap slot in turn, fed by the
// single read port of the tap store; a sample item holds it over every slot
// whatever tap_count holds, taking no other item meanwhile; a load does not.
// tap_count sits at byte address 0 of the register port and resets to 64.
module fir_filter_saturating_core #(
   parameter int MAX_TAPS       = 64,
   parameter int COEF_FRAC_BITS = 15
) (
   input  logic                              clock,
   input  logic                              reset,
   fsp_req_if.sink                           req_bus,
   fsp_rsp_if.source                         rsp_bus,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [fsp_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [fsp_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [fsp_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);

   logic                          push_valid, push_ready;
   logic                          pop_valid, pop_ready;
   fsp_pkg::cmd_type              push_data, pop_data;
   logic [fsp_pkg::TAPCNT_W-1:0]  tap_count;

   fsp_front #(
      .MAX_TAPS (MAX_TAPS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .tap_count  (tap_count)
   );

   fsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   fsp_back #(
      .MAX_TAPS       (MAX_TAPS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (pop_valid),
      .cmd_ready (pop_ready),
      .cmd_data  (pop_data),
      .tap_count (tap_count),
      .rsp_bus   (rsp_bus)
   );

endmodule

[verif/testbench.sv]
// Self-checking testbench for the saturating direct-form FIR filter core.
module testbench;
   import fsp_pkg::*;

   localparam int MAX_TAPS       = 64;
   localparam int COEF_FRAC_BITS = 15;
   // a sample occupies the back end over every tap slot; two more may sit queued
   localparam int SETTLE_CYCLES  = 3 * (MAX_TAPS + 6) + 60;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int CALM_FROM      = 10000;
   localparam int CALM_TO        = 16000;
   localparam int HOLD_AT        = 40;
   localparam int HOLD_CYCLES    = 600;
   localparam int ITEMS_PER_PHASE = 65;
   // register map: tap_count, then an unused slot
   localparam int SPARE_REG = 1;
   localparam logic [CSR_ADDR_W-1:0] TAP_COUNT_ADDR = CSR_ADDR_W'(4 * REG_TAP_COUNT);
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR     = CSR_ADDR_W'(4 * SPARE_REG);

   typedef struct {
      op_type                     op;
      logic                       start;
      logic signed [SAMPLE_W-1:0] sample;
      logic [INDEX_W-1:0]         index;
      logic signed [COEF_W-1:0]   coef;
   } filter_item_t;

   logic clock;
   logic reset;
   logic psel, penable, pwrite, pready;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata, prdata;

   fsp_req_if req_bus ();
   fsp_rsp_if rsp_bus ();

   fir_filter_saturating_core #(
      .MAX_TAPS       (MAX_TAPS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Filter state as the testbench sees it
   logic signed [SAMPLE_W-1:0] delay_line [MAX_TAPS];
   logic signed [COEF_W-1:0]   tap_weight [MAX_TAPS];
   logic [TAPCNT_W-1:0]        taps_in_use;

   filter_item_t               pending_items [$];
   logic signed [SAMPLE_W-1:0] expected_filtered [$];

   int  cycle;
   int  mismatches;
   int  accepted_items;
   int  samples_checked;
   int  loads_accepted;
   int  settings_run;
   int  hold_left;
   bit  hold_done;
   wire calm = (cycle >= CALM_FROM) && (cycle < CALM_TO);

   // Clock and free-running cycle count with timeout
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle,
                  expected_filtered.size());
         $display("status: fail");
         $finish;
      end
   end

   // Update the filter state for an accepted item and queue its expected output
   task automatic accept_item(input filter_item_t it);
      longint acc;
      longint y;
      int     n;
      begin
         if (it.op == OP_LOAD) begin
            if (it.index < MAX_TAPS) tap_weight[it.index] = it.coef;
            loads_accepted++;
         end else begin
            if (it.start) begin
               for (int k = 0; k < MAX_TAPS; k++) delay_line[k] = '0;
            end
            for (int k = MAX_TAPS - 1; k > 0; k--) delay_line[k] = delay_line[k-1];
            delay_line[0] = it.sample;
            n = (taps_in_use > MAX_TAPS) ? MAX_TAPS : int'(taps_in_use);
            acc = 0;
            for (int k = 0; k < n; k++)
               acc += longint'(tap_weight[k]) * longint'(delay_line[k]);
            // signed division truncates toward zero
            y = acc / (longint'(1) <<< COEF_FRAC_BITS);
            if (y > OUT_LIMIT) y = OUT_LIMIT;
            if (y < -OUT_LIMIT) y = -OUT_LIMIT;
            expected_filtered.push_back(SAMPLE_W'(y));
         end
      end
   endtask

   // Input driver: offers queued items, idling at random between them
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            accept_item(pending_items.pop_front());
            accepted_items++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_items.size() != 0 && (calm || $urandom_range(99) >= 24)) begin
               req_bus.valid             <= 1'b1;
               req_bus.operation         <= pending_items[0].op;
               req_bus.start_of_block    <= pending_items[0].start;
               req_bus.sample_value      <= pending_items[0].sample;
               req_bus.coefficient_index <= pending_items[0].index;
               req_bus.coefficient_value <= pending_items[0].coef;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor and receiver, with one long hold-off to back up the block
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_filtered.size() == 0) begin
               $display("%0t: unexpected result %0d", $time, rsp_bus.filtered_sample);
               mismatches++;
            end else begin
               if (rsp_bus.filtered_sample !== expected_filtered[0]) begin
                  $display("%0t: filtered_sample expected %0d actual %0d", $time,
                           expected_filtered[0], rsp_bus.filtered_sample);
                  mismatches++;
               end
               void'(expected_filtered.pop_front());
               samples_checked++;
            end
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!hold_done && accepted_items >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= calm || ($urandom_range(99) >= 24);
         end
      end
   end

   function automatic filter_item_t make_item(op_type op, logic start, int sample,
                                              int index, int coef);
      filter_item_t it;
      it.op     = op;
      it.start  = start;
      it.sample = SAMPLE_W'(sample);
      it.index  = INDEX_W'(index);
      it.coef   = COEF_W'(coef);
      return it;
   endfunction

   function automatic int random_word(bit narrow);
      int pick;
      pick = $urandom_range(7);
      if (pick == 0) begin
         case ($urandom_range(3))
            0: return 32767;
            1: return -32768;
            2: return 0;
            default: return -1;
         endcase
      end
      if (narrow) return $urandom_range(4096) - 2048;
      return $urandom_range(65535) - 32768;
   endfunction

   function automatic filter_item_t random_item();
      if ($urandom_range(99) < 30)
         return make_item(OP_LOAD, 1'($urandom), random_word(0), $urandom_range(63),
                          random_word($urandom_range(2) != 0));
      return make_item(OP_FILTER, $urandom_range(19) == 0, random_word(0),
                       $urandom_range(63), random_word(0));
   endfunction

   // Wait until every item is taken and every result checked, then let the core settle
   task automatic drain();
      begin
         while (pending_items.size() != 0 || req_bus.valid || expected_filtered.size() != 0)
            @(posedge clock);
         repeat (SETTLE_CYCLES) @(posedge clock);
      end
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      begin
         @(posedge clock);
         psel    <= 1'b1;
         penable <= 1'b0;
         pwrite  <= 1'b1;
         paddr   <= addr;
         pwdata  <= data;
         @(posedge clock);
         penable <= 1'b1;
         do @(posedge clock); while (!pready);
         psel    <= 1'b0;
         penable <= 1'b0;
         if (addr == TAP_COUNT_ADDR) taps_in_use = data[TAPCNT_W-1:0];
      end
   endtask

   // Read tap_count back; data is taken mid-cycle during the access phase
   task automatic check_tap_count();
      logic [CSR_DATA_W-1:0] rd;
      logic                  rdy;
      begin
         @(posedge clock);
         psel    <= 1'b1;
         penable <= 1'b0;
         pwrite  <= 1'b0;
         paddr   <= TAP_COUNT_ADDR;
         @(posedge clock);
         penable <= 1'b1;
         do begin
            @(negedge clock);
            rd  = prdata;
            rdy = pready;
            @(posedge clock);
         end while (!rdy);
         psel    <= 1'b0;
         penable <= 1'b0;
         if (rd !== CSR_DATA_W'(taps_in_use)) begin
            $display("%0t: tap_count read expected %0d actual %0d", $time, taps_in_use, rd);
            mismatches++;
         end
      end
   endtask

   task automatic run_setting(input int count, input int n_random);
      begin
         csr_write(TAP_COUNT_ADDR, CSR_DATA_W'(count));
         check_tap_count();
         settings_run++;
         repeat (n_random) pending_items.push_back(random_item());
         drain();
      end
   endtask

   // Stimulus sequence
   initial begin
      reset   = 1'b1;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = '0;
      req_bus.valid             = 1'b0;
      req_bus.operation         = OP_FILTER;
      req_bus.start_of_block    = 1'b0;
      req_bus.sample_value      = '0;
      req_bus.coefficient_index = '0;
      req_bus.coefficient_value = '0;
      rsp_bus.ready             = 1'b0;
      for (int k = 0; k < MAX_TAPS; k++) begin
         delay_line[k] = '0;
         tap_weight[k] = '0;
      end
      taps_in_use = TAPCNT_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      check_tap_count();
      // a write beyond the register list leaves tap_count alone
      csr_write(SPARE_ADDR, 32'h0000_005a);
      check_tap_count();

      // Directed: extreme weights, positive and negative saturation
      pending_items.push_back(make_item(OP_LOAD,   1'b0, 0,      0,  -32768));
      pending_items.push_back(make_item(OP_LOAD,   1'b0, 0,      1,  -32768));
      pending_items.push_back(make_item(OP_LOAD,   1'b0, 0,      63, 32767));
      pending_items.push_back(make_item(OP_FILTER, 1'b1, -32768, 0,  0));
      pending_items.push_back(make_item(OP_FILTER, 1'b0, 32767,  0,  0));
      pending_items.push_back(make_item(OP_FILTER, 1'b0, 32767,  0,  0));
      // ignored fields carry junk on both kinds of item
      pending_items.push_back(make_item(OP_FILTER, 1'b1, 0,      63, -1));
      pending_items.push_back(make_item(OP_LOAD,   1'b1, -32768, 2,  12345));
      // tiny negative sum truncates toward zero
      pending_items.push_back(make_item(OP_LOAD,   1'b0, 0,      0,  1));
      pending_items.push_back(make_item(OP_LOAD,   1'b0, 0,      1,  0));
      pending_items.push_back(make_item(OP_LOAD,   1'b0, 0,      2,  0));
      pending_items.push_back(make_item(OP_FILTER, 1'b1, -1,     0,  0));
      pending_items.push_back(make_item(OP_FILTER, 1'b0, 1,      0,  0));
      pending_items.push_back(make_item(OP_FILTER, 1'b0, -32768, 0,  0));
      pending_items.push_back(make_item(OP_FILTER, 1'b0, 32767,  0,  0));
      repeat (100) pending_items.push_back(random_item());
      drain();

      // Further settings: single tap, none, above the maximum, full, and random
      run_setting(1, ITEMS_PER_PHASE);
      run_setting(0, ITEMS_PER_PHASE);
      run_setting(127, ITEMS_PER_PHASE);
      run_setting(64, ITEMS_PER_PHASE);
      run_setting($urandom_range(63, 2), ITEMS_PER_PHASE);
      run_setting($urandom_range(127), ITEMS_PER_PHASE);

      $display("covered %0d filtered samples and %0d coefficient loads", samples_checked,
               loads_accepted);
      $display("over %0d tap_count settings plus reset, with one long output stall",
               settings_run);
      if (expected_filtered.size() != 0)
         $display("%0d expected results never arrived", expected_filtered.size());
      if (mismatches == 0 && expected_filtered.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

[fir_filter_saturating_core.f]
design/fsp_pkg.sv
design/fsp_req_if.sv
design/fsp_queue.sv
design/fsp_front.sv
design/fsp_back.sv
design/fir_filter_saturating_core.sv
verif/testbench.sv
